// ===== sv/pixel_pair_color_converter_assert.svh =====
// assertion macros used by the converter top level
`ifndef PIXEL_PAIR_COLOR_CONVERTER_ASSERT_SVH
`define PIXEL_PAIR_COLOR_CONVERTER_ASSERT_SVH

// same-cycle implication, skipped while reset is asserted
`define PPCC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, skipped while reset is asserted
`define PPCC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ppcc_pkg.sv =====
// shared types, register codes and mode decode for the pixel pair converter
package ppcc_pkg;

    localparam int CfgIndexW = 1;
    localparam int CfgDataW  = 2;

    localparam logic [CfgIndexW-1:0] REG_SOURCE_FORMAT = 1'd0;
    localparam logic [CfgIndexW-1:0] REG_TARGET_SPACE  = 1'd1;

    localparam logic SRC_YUV420 = 1'b0;
    localparam logic SRC_RGB24  = 1'b1;

    localparam logic [1:0] TGT_LUMA = 2'd0;
    localparam logic [1:0] TGT_YUV  = 2'd1;
    localparam logic [1:0] TGT_RGB  = 2'd2;

    localparam logic [1:0] CHANNELS_LUMA = 2'd1;
    localparam logic [1:0] CHANNELS_FULL = 2'd3;

    typedef enum logic [2:0] {
        MODE_Y_PASS,
        MODE_YUV_SCALE,
        MODE_YUV_RGB,
        MODE_RGB_LUMA,
        MODE_NONE
    } mode_t;

    typedef struct packed {
        logic  en_mul;
        logic  en_sum;
        mode_t mode;
    } lane_ctl_t;

    function automatic mode_t conv_mode(logic src, logic [1:0] tgt);
        mode_t m;
        m = MODE_NONE;
        if (src == SRC_YUV420) begin
            case (tgt)
                TGT_LUMA: m = MODE_Y_PASS;
                TGT_YUV:  m = MODE_YUV_SCALE;
                TGT_RGB:  m = MODE_YUV_RGB;
                default:  m = MODE_NONE;
            endcase
        end else if (tgt == TGT_LUMA) begin
            m = MODE_RGB_LUMA;
        end
        return m;
    endfunction

endpackage

// ===== sv/ppcc_lane.sv =====
// one pixel lane: constant products, then sums with shift and clamp
module ppcc_lane
    import ppcc_pkg::*;
(
    input  logic       aclk,
    input  lane_ctl_t  ctl,
    input  logic [7:0] luma,
    input  logic [7:0] chroma_blue,
    input  logic [7:0] chroma_red,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic [7:0] chan_a,
    output logic [7:0] chan_b,
    output logic [7:0] chan_c
);

    function automatic logic [7:0] shift_clamp(logic signed [19:0] v);
        logic signed [11:0] s;
        logic [7:0] r;
        s = 12'(v >>> 8);
        if (s < 0) begin
            r = 8'd0;
        end else if (s > 12'sd255) begin
            r = 8'd255;
        end else begin
            r = s[7:0];
        end
        return r;
    endfunction

    logic signed [19:0] ys;
    logic signed [19:0] us;
    logic signed [19:0] vs;

    logic [7:0]         luma_reg;
    logic signed [19:0] p_y298_reg;
    logic signed [19:0] p_v409_reg;
    logic signed [19:0] p_u100_reg;
    logic signed [19:0] p_v208_reg;
    logic signed [19:0] p_u516_reg;
    logic signed [19:0] p_u293_reg;
    logic signed [19:0] p_v293_reg;
    logic [15:0]        p_r76_reg;
    logic [15:0]        p_g150_reg;
    logic [15:0]        p_b29_reg;

    logic [7:0] a_reg;
    logic [7:0] b_reg;
    logic [7:0] c_reg;
    logic [7:0] a_next;
    logic [7:0] b_next;
    logic [7:0] c_next;
    logic [15:0] luma_sum;

    // offsets: chroma minus 128 is the code with its top bit flipped
    assign ys = 20'(signed'({1'b0, luma})) - 20'sd16;
    assign us = 20'(signed'({~chroma_blue[7], chroma_blue[6:0]}));
    assign vs = 20'(signed'({~chroma_red[7], chroma_red[6:0]}));

    always_ff @(posedge aclk) begin
        if (ctl.en_mul) begin
            luma_reg   <= luma;
            p_y298_reg <= ys * 20'sd298;
            p_v409_reg <= vs * 20'sd409;
            p_u100_reg <= us * 20'sd100;
            p_v208_reg <= vs * 20'sd208;
            p_u516_reg <= us * 20'sd516;
            p_u293_reg <= us * 20'sd293;
            p_v293_reg <= vs * 20'sd293;
            p_r76_reg  <= 16'(red) * 16'd76;
            p_g150_reg <= 16'(green) * 16'd150;
            p_b29_reg  <= 16'(blue) * 16'd29;
        end
    end

    assign luma_sum = p_r76_reg + p_g150_reg + p_b29_reg;

    always_comb begin
        a_next = 8'd0;
        b_next = 8'd0;
        c_next = 8'd0;
        unique case (ctl.mode)
            MODE_Y_PASS: begin
                a_next = luma_reg;
            end
            MODE_YUV_SCALE: begin
                a_next = shift_clamp(p_y298_reg);
                b_next = shift_clamp(p_u293_reg);
                c_next = shift_clamp(p_v293_reg);
            end
            MODE_YUV_RGB: begin
                a_next = shift_clamp(p_y298_reg + p_v409_reg);
                b_next = shift_clamp(p_y298_reg - p_u100_reg - p_v208_reg);
                c_next = shift_clamp(p_y298_reg + p_u516_reg);
            end
            MODE_RGB_LUMA: begin
                a_next = luma_sum[15:8];
            end
            default: begin
                a_next = 8'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.en_sum) begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    assign chan_a = a_reg;
    assign chan_b = b_reg;
    assign chan_c = c_reg;

endmodule

// ===== sv/pixel_pair_color_converter.sv =====
// top level: config registers, two pixel lanes and the merging output register
//
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    two lumas, shared u/v, two rgb triples
//  m_       out        m_valid/m_ready    two 3-channel pixels, channel_count, unsupported
//  cfg_     in         cfg_we             cfg_index, cfg_wdata
//
// one item per clock sustained while m_ready stays high; an accepted item reaches m_valid
// through the product stage, the sum/clamp stage and the output register
// each stage holds one item and frees itself as soon as the next one moves
// synchronous active-low reset empties the pipeline and loads the register defaults
module pixel_pair_color_converter
    import ppcc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_luma_first,
    input  logic [7:0]           s_luma_second,
    input  logic [7:0]           s_chroma_blue,
    input  logic [7:0]           s_chroma_red,
    input  logic [7:0]           s_red_first,
    input  logic [7:0]           s_green_first,
    input  logic [7:0]           s_blue_first,
    input  logic [7:0]           s_red_second,
    input  logic [7:0]           s_green_second,
    input  logic [7:0]           s_blue_second,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_first_chan_a,
    output logic [7:0]           m_first_chan_b,
    output logic [7:0]           m_first_chan_c,
    output logic [7:0]           m_second_chan_a,
    output logic [7:0]           m_second_chan_b,
    output logic [7:0]           m_second_chan_c,
    output logic [1:0]           m_channel_count,
    output logic                 m_unsupported
);

`include "pixel_pair_color_converter_assert.svh"

    logic       source_format_reg;
    logic [1:0] target_space_reg;

    logic mul_valid_reg;
    logic sum_valid_reg;
    logic out_valid_reg;
    logic mul_valid_next;
    logic sum_valid_next;
    logic out_valid_next;

    logic load_out;
    logic adv_sum;
    logic adv_mul;

    mode_t     mode;
    lane_ctl_t ctl;

    logic [7:0] first_a;
    logic [7:0] first_b;
    logic [7:0] first_c;
    logic [7:0] second_a;
    logic [7:0] second_b;
    logic [7:0] second_c;

    logic [7:0] first_a_reg;
    logic [7:0] first_b_reg;
    logic [7:0] first_c_reg;
    logic [7:0] second_a_reg;
    logic [7:0] second_b_reg;
    logic [7:0] second_c_reg;
    logic [1:0] channel_count_reg;
    logic       unsupported_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_format_reg <= SRC_YUV420;
            target_space_reg  <= TGT_RGB;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SOURCE_FORMAT: source_format_reg <= cfg_wdata[0];
                REG_TARGET_SPACE:  target_space_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign mode = conv_mode(source_format_reg, target_space_reg);

    // stage advance, from the output back to the input
    assign load_out = sum_valid_reg && (!out_valid_reg || m_ready);
    assign adv_sum  = !sum_valid_reg || load_out;
    assign adv_mul  = !mul_valid_reg || adv_sum;
    assign s_ready  = adv_mul;

    assign ctl.en_mul = s_valid && s_ready;
    assign ctl.en_sum = mul_valid_reg && adv_sum;
    assign ctl.mode   = mode;

    assign mul_valid_next = ctl.en_mul || (mul_valid_reg && !adv_sum);
    assign sum_valid_next = ctl.en_sum || (sum_valid_reg && !load_out);
    assign out_valid_next = load_out || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mul_valid_reg <= mul_valid_next;
            sum_valid_reg <= sum_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    ppcc_lane u_lane_first (
        .aclk        (aclk),
        .ctl         (ctl),
        .luma        (s_luma_first),
        .chroma_blue (s_chroma_blue),
        .chroma_red  (s_chroma_red),
        .red         (s_red_first),
        .green       (s_green_first),
        .blue        (s_blue_first),
        .chan_a      (first_a),
        .chan_b      (first_b),
        .chan_c      (first_c)
    );

    ppcc_lane u_lane_second (
        .aclk        (aclk),
        .ctl         (ctl),
        .luma        (s_luma_second),
        .chroma_blue (s_chroma_blue),
        .chroma_red  (s_chroma_red),
        .red         (s_red_second),
        .green       (s_green_second),
        .blue        (s_blue_second),
        .chan_a      (second_a),
        .chan_b      (second_b),
        .chan_c      (second_c)
    );

    // merge both lanes with the per-item flags
    always_ff @(posedge aclk) begin
        if (load_out) begin
            first_a_reg       <= first_a;
            first_b_reg       <= first_b;
            first_c_reg       <= first_c;
            second_a_reg      <= second_a;
            second_b_reg      <= second_b;
            second_c_reg      <= second_c;
            channel_count_reg <= (target_space_reg == TGT_LUMA) ? CHANNELS_LUMA
                                                                : CHANNELS_FULL;
            unsupported_reg   <= (mode == MODE_NONE);
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_first_chan_a  = first_a_reg;
    assign m_first_chan_b  = first_b_reg;
    assign m_first_chan_c  = first_c_reg;
    assign m_second_chan_a = second_a_reg;
    assign m_second_chan_b = second_b_reg;
    assign m_second_chan_c = second_c_reg;
    assign m_channel_count = channel_count_reg;
    assign m_unsupported   = unsupported_reg;

    `PPCC_ASSERT_IMP(a_unsupported_zero, aclk, aresetn,
        m_valid && m_unsupported,
        (m_first_chan_a == 8'd0) && (m_first_chan_b == 8'd0) && (m_first_chan_c == 8'd0) &&
        (m_second_chan_a == 8'd0) && (m_second_chan_b == 8'd0) && (m_second_chan_c == 8'd0),
        "unsupported item carries nonzero channels")
    `PPCC_ASSERT_IMP(a_luma_bc_zero, aclk, aresetn,
        m_valid && (m_channel_count == CHANNELS_LUMA),
        (m_first_chan_b == 8'd0) && (m_first_chan_c == 8'd0) &&
        (m_second_chan_b == 8'd0) && (m_second_chan_c == 8'd0),
        "luma item carries nonzero b or c channel")
    `PPCC_ASSERT_NXT(a_accept_fills_mul, aclk, aresetn,
        ctl.en_mul, mul_valid_reg,
        "accepted item did not reach the product stage")
    `PPCC_ASSERT_NXT(a_load_fills_out, aclk, aresetn,
        load_out, m_valid,
        "output register load lost")

endmodule

// ===== bench/tb_pixel_pair_color_converter.sv =====
// self-checking testbench for the pixel pair color converter with its own prediction
module tb_pixel_pair_color_converter;
    import ppcc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD  = 12;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_WAIT  = 6;
    localparam logic [1:0]  TGT_UNUSED  = 2'd3;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
    } pixel_pair_t;

    typedef struct packed {
        logic [7:0] first_chan_a;
        logic [7:0] first_chan_b;
        logic [7:0] first_chan_c;
        logic [7:0] second_chan_a;
        logic [7:0] second_chan_b;
        logic [7:0] second_chan_c;
        logic [1:0] channel_count;
        logic       unsupported;
    } converted_pair_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CfgIndexW-1:0] cfg_index = REG_SOURCE_FORMAT;
    logic [CfgDataW-1:0]  cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_luma_first = '0;
    logic [7:0]           s_luma_second = '0;
    logic [7:0]           s_chroma_blue = '0;
    logic [7:0]           s_chroma_red = '0;
    logic [7:0]           s_red_first = '0;
    logic [7:0]           s_green_first = '0;
    logic [7:0]           s_blue_first = '0;
    logic [7:0]           s_red_second = '0;
    logic [7:0]           s_green_second = '0;
    logic [7:0]           s_blue_second = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [7:0]           m_first_chan_a;
    logic [7:0]           m_first_chan_b;
    logic [7:0]           m_first_chan_c;
    logic [7:0]           m_second_chan_a;
    logic [7:0]           m_second_chan_b;
    logic [7:0]           m_second_chan_c;
    logic [1:0]           m_channel_count;
    logic                 m_unsupported;

    logic                 src_fmt = SRC_YUV420;
    logic [1:0]           tgt_space = TGT_RGB;

    pixel_pair_t          pending_pairs[$];
    converted_pair_t      expected_pairs[$];
    pixel_pair_t          next_pair;
    converted_pair_t      got_pair;
    converted_pair_t      want_pair;

    int                   fail_count = 0;
    int                   cycle_count = 0;
    int                   burst_left = 1;
    int                   gap_left = 0;
    int                   stall_mode = 0;
    int                   stall_left = 0;
    int                   stall_phase = 0;

    pixel_pair_color_converter dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_luma_first    (s_luma_first),
        .s_luma_second   (s_luma_second),
        .s_chroma_blue   (s_chroma_blue),
        .s_chroma_red    (s_chroma_red),
        .s_red_first     (s_red_first),
        .s_green_first   (s_green_first),
        .s_blue_first    (s_blue_first),
        .s_red_second    (s_red_second),
        .s_green_second  (s_green_second),
        .s_blue_second   (s_blue_second),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_first_chan_a  (m_first_chan_a),
        .m_first_chan_b  (m_first_chan_b),
        .m_first_chan_c  (m_first_chan_c),
        .m_second_chan_a (m_second_chan_a),
        .m_second_chan_b (m_second_chan_b),
        .m_second_chan_c (m_second_chan_c),
        .m_channel_count (m_channel_count),
        .m_unsupported   (m_unsupported)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // floor divide by 256, then saturate to a byte
    function automatic logic [7:0] shift_saturate(int acc);
        int q;
        q = acc >>> 8;
        if (q < 0) return 8'd0;
        if (q > 255) return 8'd255;
        return q[7:0];
    endfunction

    function automatic logic [23:0] yuv_to_rgb(logic [7:0] yv, logic [7:0] uv, logic [7:0] vv);
        int y;
        int u;
        int v;
        y = int'(yv) - 16;
        u = int'(uv) - 128;
        v = int'(vv) - 128;
        return {shift_saturate(298 * y + 409 * v),
                shift_saturate(298 * y - 100 * u - 208 * v),
                shift_saturate(298 * y + 516 * u)};
    endfunction

    function automatic logic [23:0] yuv_rescale(logic [7:0] yv, logic [7:0] uv, logic [7:0] vv);
        return {shift_saturate((int'(yv) - 16) * 298),
                shift_saturate((int'(uv) - 128) * 293),
                shift_saturate((int'(vv) - 128) * 293)};
    endfunction

    function automatic logic [7:0] rgb_to_luma(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int acc;
        acc = 76 * int'(r) + 150 * int'(g) + 29 * int'(b);
        return acc[15:8];
    endfunction

    function automatic converted_pair_t convert_pair(pixel_pair_t p, logic src, logic [1:0] tgt);
        converted_pair_t c;
        logic [23:0] first_px;
        logic [23:0] second_px;
        first_px = '0;
        second_px = '0;
        c = '0;
        c.channel_count = (tgt == TGT_LUMA) ? CHANNELS_LUMA : CHANNELS_FULL;
        if (src == SRC_YUV420) begin
            case (tgt)
                TGT_LUMA: begin
                    first_px = {p.luma_first, 16'd0};
                    second_px = {p.luma_second, 16'd0};
                end
                TGT_YUV: begin
                    first_px = yuv_rescale(p.luma_first, p.chroma_blue, p.chroma_red);
                    second_px = yuv_rescale(p.luma_second, p.chroma_blue, p.chroma_red);
                end
                TGT_RGB: begin
                    first_px = yuv_to_rgb(p.luma_first, p.chroma_blue, p.chroma_red);
                    second_px = yuv_to_rgb(p.luma_second, p.chroma_blue, p.chroma_red);
                end
                default: c.unsupported = 1'b1;
            endcase
        end else if (tgt == TGT_LUMA) begin
            first_px = {rgb_to_luma(p.red_first, p.green_first, p.blue_first), 16'd0};
            second_px = {rgb_to_luma(p.red_second, p.green_second, p.blue_second), 16'd0};
        end else begin
            c.unsupported = 1'b1;
        end
        {c.first_chan_a, c.first_chan_b, c.first_chan_c} = first_px;
        {c.second_chan_a, c.second_chan_b, c.second_chan_c} = second_px;
        return c;
    endfunction

    function automatic logic [7:0] random_sample();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) return 8'd0;
        if (pick == 1) return 8'd255;
        if (pick == 2) return 8'($urandom_range(112, 144));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic pixel_pair_t random_pair();
        pixel_pair_t p;
        p.luma_first = random_sample();
        p.luma_second = random_sample();
        p.chroma_blue = random_sample();
        p.chroma_red = random_sample();
        p.red_first = random_sample();
        p.green_first = random_sample();
        p.blue_first = random_sample();
        p.red_second = random_sample();
        p.green_second = random_sample();
        p.blue_second = random_sample();
        return p;
    endfunction

    function automatic pixel_pair_t yuv_pair(logic [7:0] y1, logic [7:0] y2,
                                             logic [7:0] u, logic [7:0] v);
        pixel_pair_t p;
        p = random_pair();
        p.luma_first = y1;
        p.luma_second = y2;
        p.chroma_blue = u;
        p.chroma_red = v;
        return p;
    endfunction

    function automatic pixel_pair_t flat_pair(logic [7:0] v);
        return {10{v}};
    endfunction

    function automatic pixel_pair_t sampled_pair();
        return {s_luma_first, s_luma_second, s_chroma_blue, s_chroma_red,
                s_red_first, s_green_first, s_blue_first,
                s_red_second, s_green_second, s_blue_second};
    endfunction

    task automatic cfg_write(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_SOURCE_FORMAT) src_fmt = value[0];
        else tgt_space = value;
    endtask

    // sampled mid-cycle so the sender's updates have settled
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_pairs.size() != 0 || s_valid || expected_pairs.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic run_setting(logic src, logic [1:0] tgt, int count, bit with_extremes);
        // upper data bit is don't-care for the one-bit source register
        cfg_write(REG_SOURCE_FORMAT, {1'($urandom_range(0, 1)), src});
        cfg_write(REG_TARGET_SPACE, tgt);
        if (with_extremes) begin
            pending_pairs.push_back(flat_pair(8'd0));
            pending_pairs.push_back(flat_pair(8'd255));
        end
        repeat (count) pending_pairs.push_back(random_pair());
        wait_idle();
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_pairs.push_back(convert_pair(sampled_pair(), src_fmt, tgt_space));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_pairs.size() != 0) begin
                    next_pair = pending_pairs.pop_front();
                    s_luma_first <= next_pair.luma_first;
                    s_luma_second <= next_pair.luma_second;
                    s_chroma_blue <= next_pair.chroma_blue;
                    s_chroma_red <= next_pair.chroma_red;
                    s_red_first <= next_pair.red_first;
                    s_green_first <= next_pair.green_first;
                    s_blue_first <= next_pair.blue_first;
                    s_red_second <= next_pair.red_second;
                    s_green_second <= next_pair.green_second;
                    s_blue_second <= next_pair.blue_second;
                    s_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 32);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern switches between free flow, light, heavy and periodic
    always @(posedge aclk) begin
        logic rdy_next;
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 90);
        end else begin
            stall_left--;
        end
        stall_phase = (stall_phase + 1) % 3;
        case (stall_mode)
            0: rdy_next = 1'b1;
            1: rdy_next = ($urandom_range(0, 3) != 0);
            2: rdy_next = ($urandom_range(0, 3) == 0);
            default: rdy_next = (stall_phase != 0);
        endcase
        m_ready <= rdy_next;

        if (aresetn && m_valid && m_ready) begin
            got_pair = {m_first_chan_a, m_first_chan_b, m_first_chan_c,
                        m_second_chan_a, m_second_chan_b, m_second_chan_c,
                        m_channel_count, m_unsupported};
            if (expected_pairs.size() == 0) begin
                $error("result item with no pending expectation");
                fail_count++;
            end else begin
                want_pair = expected_pairs.pop_front();
                check_field("first_chan_a", want_pair.first_chan_a, got_pair.first_chan_a);
                check_field("first_chan_b", want_pair.first_chan_b, got_pair.first_chan_b);
                check_field("first_chan_c", want_pair.first_chan_c, got_pair.first_chan_c);
                check_field("second_chan_a", want_pair.second_chan_a, got_pair.second_chan_a);
                check_field("second_chan_b", want_pair.second_chan_b, got_pair.second_chan_b);
                check_field("second_chan_c", want_pair.second_chan_c, got_pair.second_chan_c);
                check_field("channel_count", 8'(want_pair.channel_count),
                            8'(got_pair.channel_count));
                check_field("unsupported", 8'(want_pair.unsupported),
                            8'(got_pair.unsupported));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("pixel_pair_color_converter verification failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: yuv source to rgb
        pending_pairs.push_back(yuv_pair(8'd16, 8'd235, 8'd128, 8'd128));
        pending_pairs.push_back(yuv_pair(8'd0, 8'd255, 8'd0, 8'd255));
        pending_pairs.push_back(yuv_pair(8'd255, 8'd0, 8'd255, 8'd0));
        pending_pairs.push_back(yuv_pair(8'd128, 8'd128, 8'd0, 8'd0));
        wait_idle();

        for (int round = 0; round < 2; round++) begin
            for (int k = 0; k < 8; k++) begin
                int combo;
                logic src;
                logic [1:0] tgt;
                combo = (round == 0) ? k : 7 - k;
                src = combo[2];
                tgt = combo[1:0];
                if (tgt == TGT_UNUSED || (src != SRC_YUV420 && tgt != TGT_LUMA))
                    run_setting(src, tgt, 15, round == 0);
                else
                    run_setting(src, tgt, 150, round == 0);
            end
        end

        if (fail_count == 0) begin
            $display("pixel_pair_color_converter verification clean");
        end else begin
            $display("pixel_pair_color_converter verification failed");
        end
        $finish;
    end

endmodule
